FILE: rtl/core/swerm_pkg.sv
// shared types and constants for the sliding window event rate meter
package swerm_pkg;

    localparam int MODE_W = 2;
    localparam int NOW_W  = 32;
    localparam int CFG_W  = 32;
    localparam int OUT_CW = 7;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 32'd1000000;

    typedef enum logic [MODE_W-1:0] {
        MODE_EVENT = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EXP_RD,
        S_EXP_CMP,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/sliding_window_event_rate_meter.sv
// top level: two-channel sliding window event rate meter
//
// input channel (i_valid/o_ready) carries i_mode, i_player and i_now; each
// request yields exactly one result on the output channel (o_valid/i_ready)
// with the selected channel's count, peak and an overflow flag.
// modes: event pushes i_now into the selected ring unless it is full, tick
// retires in both rings every oldest entry older than the window, clear
// empties both rings and peaks, query changes nothing.
// one request is worked at a time: o_ready is high only in the idle state.
// event, clear and query pass from exec to done; a tick walks each ring
// from its head through the timestamp memory, one retired entry per cycle,
// and then passes to done.
// the window register is written through i_cfg_wr_en/i_cfg_wr_data. the user
// must write it only while no request is in flight; the block does not enforce it.
// a finished result sits in an output register; the next request is taken
// while it waits, and a later result holds in place until i_ready frees
// that register. synchronous reset empties both rings, zeroes the peaks,
// restores the window to 1000000 ticks and drops any pending result; the
// timestamp memory itself is not cleared.
module sliding_window_event_rate_meter #(
    parameter int RING_DEPTH = 64,
    parameter int TIME_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [swerm_pkg::MODE_W-1:0] i_mode,
    input  logic                        i_player,
    input  logic [swerm_pkg::NOW_W-1:0]  i_now,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [swerm_pkg::OUT_CW-1:0] o_event_count,
    output logic [swerm_pkg::OUT_CW-1:0] o_peak_count,
    output logic                        o_overflow,
    input  logic                        i_cfg_wr_en,
    input  logic [swerm_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    import swerm_pkg::*;

    localparam int IW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int AW   = IW + 1;
    localparam int CMPW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    localparam logic [IW:0]   DEPTH_S = (IW + 1)'(RING_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(RING_DEPTH - 1);

    t_state r_state, n_state;

    t_mode                 r_mode;
    logic                  r_player;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_ovf;
    logic                  r_ch;
    logic [CFG_W-1:0]      r_window;

    logic [IW-1:0] r_head [2];
    logic [CW-1:0] r_fill [2];
    logic [CW-1:0] r_peak [2];

    logic                  r_o_valid;
    logic [OUT_CW-1:0]     r_o_count;
    logic [OUT_CW-1:0]     r_o_peak;
    logic                  r_o_ovf;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_sel;
    logic [IW-1:0]         w_head;
    logic [CW-1:0]         w_fill;
    logic [CW-1:0]         w_peak;
    logic [IW-1:0]         w_head_inc;
    logic [IW:0]           w_slot_sum;
    logic [IW-1:0]         w_slot;
    logic [CW-1:0]         w_fill_inc;
    logic [TIME_WIDTH-1:0] w_age;
    logic                  w_retire;
    logic                  w_full;

    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic                  w_mem_re;
    logic [AW-1:0]         w_mem_raddr;
    logic [TIME_WIDTH-1:0] w_mem_rdata;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    // during the expire walk the ring under work is chosen, otherwise the requested one
    assign w_sel = (r_state == S_EXP_RD || r_state == S_EXP_CMP) ? r_ch : r_player;

    assign w_head     = r_head[w_sel];
    assign w_fill     = r_fill[w_sel];
    assign w_peak     = r_peak[w_sel];
    assign w_head_inc = (w_head == LAST_IX) ? '0 : w_head + 1'b1;
    assign w_slot_sum = {1'b0, w_head} + (IW + 1)'(w_fill);
    assign w_slot     = (w_slot_sum >= DEPTH_S) ? IW'(w_slot_sum - DEPTH_S) : IW'(w_slot_sum);
    assign w_fill_inc = w_fill + 1'b1;
    assign w_full     = (w_fill >= DEPTH_C);

    // read data holds the stamp at the current head while in the compare state
    assign w_age    = r_now - w_mem_rdata;
    assign w_retire = CMPW'(w_age) > CMPW'(r_window);

    swerm_ram #(
        .DATA_W (TIME_WIDTH),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (r_now),
        .i_rd_en   (w_mem_re),
        .i_rd_addr (w_mem_raddr),
        .o_rd_data (w_mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_mode == MODE_TICK) ? S_EXP_RD : S_DONE;
            end
            S_EXP_RD: begin
                if (w_fill != '0) begin
                    n_state = S_EXP_CMP;
                end else begin
                    n_state = r_ch ? S_DONE : S_EXP_RD;
                end
            end
            S_EXP_CMP: begin
                if (w_retire && w_fill != CW'(1)) begin
                    n_state = S_EXP_CMP;
                end else begin
                    n_state = r_ch ? S_DONE : S_EXP_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = {r_player, w_slot};
        w_mem_re    = 1'b0;
        w_mem_raddr = {r_ch, w_head};
        unique case (r_state)
            S_EXEC: begin
                w_mem_we = (r_mode == MODE_EVENT) && !w_full;
            end
            S_EXP_RD: begin
                w_mem_re = 1'b1;
            end
            S_EXP_CMP: begin
                // fetch the next entry ahead of the compare
                w_mem_re    = 1'b1;
                w_mem_raddr = {r_ch, w_head_inc};
            end
            default: begin
                w_mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= WINDOW_RESET;
            r_ch     <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_head[k] <= '0;
                r_fill[k] <= '0;
                r_peak[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_EXEC: begin
                    r_ch <= 1'b0;
                    if (r_mode == MODE_EVENT && !w_full) begin
                        r_fill[r_player] <= w_fill_inc;
                        if (w_fill_inc > w_peak) begin
                            r_peak[r_player] <= w_fill_inc;
                        end
                    end else if (r_mode == MODE_CLEAR) begin
                        for (int k = 0; k < 2; k++) begin
                            r_head[k] <= '0;
                            r_fill[k] <= '0;
                            r_peak[k] <= '0;
                        end
                    end
                end
                S_EXP_RD: begin
                    if (w_fill == '0) begin
                        r_ch <= 1'b1;
                    end
                end
                S_EXP_CMP: begin
                    if (w_retire) begin
                        r_head[r_ch] <= w_head_inc;
                        r_fill[r_ch] <= w_fill - 1'b1;
                        if (w_fill == CW'(1)) begin
                            r_ch <= 1'b1;
                        end
                    end else begin
                        r_ch <= 1'b1;
                    end
                end
                default: begin
                    r_ch <= r_ch;
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= t_mode'(i_mode);
            r_player <= i_player;
            r_now    <= TIME_WIDTH'(i_now);
        end
        if (w_accept) begin
            r_ovf <= 1'b0;
        end else if (r_state == S_EXEC && r_mode == MODE_EVENT && w_full) begin
            r_ovf <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_count <= OUT_CW'(w_fill);
            r_o_peak  <= OUT_CW'(w_peak);
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_event_count = r_o_count;
    assign o_peak_count  = r_o_peak;
    assign o_overflow    = r_o_ovf;

endmodule

FILE: rtl/core/swerm_ram.sv
// timestamp store: one write port, one read port with registered read data
module swerm_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/swerm_chk.sv
// port-level checks for the sliding window event rate meter, with bind
module swerm_chk #(
    parameter int RING_DEPTH = 64
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [swerm_pkg::OUT_CW-1:0] o_event_count,
    input logic [swerm_pkg::OUT_CW-1:0] o_peak_count,
    input logic                        o_overflow
);

    import swerm_pkg::*;

    localparam logic [OUT_CW-1:0] DEPTH_O = OUT_CW'(RING_DEPTH);
    localparam bit COUNT_FITS = (RING_DEPTH < (1 << OUT_CW));

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_count)
            && $stable(o_peak_count) && $stable(o_overflow))
        else $error("stalled result changed");

    // one request at a time: ready drops after each accepted request
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after accepting a request");

    // an overflow result reports a full ring
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_event_count == DEPTH_O)
        else $error("overflow reported with ring not full");

    // the peak never trails the current count (checked when the depth fits the output width)
    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && COUNT_FITS |-> o_peak_count >= o_event_count)
        else $error("peak below current count");

endmodule

bind sliding_window_event_rate_meter swerm_chk #(
    .RING_DEPTH (RING_DEPTH)
) u_swerm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_event_count (o_event_count),
    .o_peak_count  (o_peak_count),
    .o_overflow    (o_overflow)
);
